### src/u8san_pkg.sv
`default_nettype none
package u8san_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [7:0] REP_B0 = 8'hEF;
  localparam logic [7:0] REP_B1 = 8'hBF;
  localparam logic [7:0] REP_B2 = 8'hBD;

  localparam logic [1:0] REP_LAST_POS = 2'd2;

  // one queue entry: replacements, then pass bytes, then replacements
  typedef struct packed {
    logic [3:0][7:0] pb;
    logic [2:0]      n_pre;
    logic [2:0]      n_pass;
    logic [1:0]      n_post;
    logic            last;
    logic            str_valid;
  } u8san_cmd_t;

  // group length from the lead byte, zero when the lead is invalid
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    priority if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic [7:0] rep_byte(input logic [1:0] pos);
    logic [7:0] r;
    unique case (pos)
      2'd0:    r = REP_B0;
      2'd1:    r = REP_B1;
      default: r = REP_B2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/u8san_in_if.sv
`default_nettype none
interface u8san_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

### src/u8san_out_if.sv
`default_nettype none
interface u8san_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_substituted;
  logic       out_last;
  logic       string_was_valid;

  modport source (output valid, output out_byte, output out_substituted,
                  output out_last, output string_was_valid, input ready);
  modport sink (input valid, input out_byte, input out_substituted,
                input out_last, input string_was_valid, output ready);
endinterface
`default_nettype wire

### src/u8san_front.sv
`default_nettype none
module u8san_front
  import u8san_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  u8san_in_if.sink    in_ch,
  input  wire logic   q_full,
  output logic        q_push,
  output u8san_cmd_t  q_cmd
);

  logic [2:0][7:0] held_r, held_nxt;
  logic [1:0]      hc_r, hc_nxt;
  logic [2:0]      glen_r, glen_nxt;
  logic            anyrep_r, anyrep_nxt;

  logic       accept;
  logic [7:0] b;
  logic       is_cont;
  logic       cont_case;
  logic [2:0] len;
  logic [2:0] n_pre;
  logic [2:0] n_pass;
  logic [1:0] n_post;
  logic       has_rep;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign is_cont     = (b[7:6] == 2'b10);
  assign cont_case   = (hc_r != 2'd0) && is_cont;
  assign len         = lead_len(b);

  always_comb begin
    held_nxt = held_r;
    hc_nxt   = hc_r;
    glen_nxt = glen_r;
    n_pre    = 3'd0;
    n_pass   = 3'd0;
    n_post   = 2'd0;
    if (cont_case) begin
      if (({1'b0, hc_r} + 3'd1) >= glen_r) begin
        n_pass   = {1'b0, hc_r} + 3'd1;
        hc_nxt   = 2'd0;
        glen_nxt = 3'd1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (hc_r == i[1:0]) begin
            held_nxt[i] = b;
          end
        end
        hc_nxt = hc_r + 2'd1;
      end
    end else begin
      // group not continued (or none held): one replacement per held byte, then rescan as a lead
      n_pre    = {1'b0, hc_r};
      hc_nxt   = 2'd0;
      glen_nxt = 3'd1;
      if (len == 3'd0) begin
        n_pre = n_pre + 3'd1;
      end else if (len == 3'd1) begin
        n_pass = 3'd1;
      end else begin
        held_nxt[0] = b;
        hc_nxt      = 2'd1;
        glen_nxt    = len;
      end
    end
    // group cut short at end of string
    if (in_ch.in_last) begin
      n_post   = hc_nxt;
      hc_nxt   = 2'd0;
      glen_nxt = 3'd1;
    end
  end

  assign has_rep    = (n_pre != 3'd0) || (n_post != 2'd0);
  assign anyrep_nxt = in_ch.in_last ? 1'b0 : (anyrep_r || has_rep);

  always_comb begin
    q_cmd.pb[0] = cont_case ? held_r[0] : b;
    q_cmd.pb[1] = (cont_case && hc_r > 2'd1) ? held_r[1] : b;
    q_cmd.pb[2] = (cont_case && hc_r > 2'd2) ? held_r[2] : b;
    q_cmd.pb[3] = b;
    q_cmd.n_pre     = n_pre;
    q_cmd.n_pass    = n_pass;
    q_cmd.n_post    = n_post;
    q_cmd.last      = in_ch.in_last;
    q_cmd.str_valid = !(anyrep_r || has_rep);
  end

  assign q_push = accept && ((n_pre != 3'd0) || (n_pass != 3'd0) || (n_post != 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r     <= 2'd0;
      glen_r   <= 3'd1;
      anyrep_r <= 1'b0;
    end else if (accept) begin
      hc_r     <= hc_nxt;
      glen_r   <= glen_nxt;
      anyrep_r <= anyrep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

`ifndef SYNTHESIS
  a_held_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r != 2'd0) |-> (glen_r >= 3'd2 && {1'b0, hc_r} < glen_r))
    else $error("held count outside group length");
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.in_last) |-> q_push)
    else $error("final byte produced no output");
`endif

endmodule
`default_nettype wire

### src/u8san_fifo.sv
`default_nettype none
module u8san_fifo
  import u8san_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire u8san_cmd_t  push_cmd,
  output logic             full,
  input  wire logic        pop,
  output u8san_cmd_t       pop_cmd,
  output logic             empty
);

  u8san_cmd_t mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

### src/u8san_back.sv
`default_nettype none
module u8san_back
  import u8san_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire u8san_cmd_t  q_cmd,
  output logic             q_pop,
  u8san_out_if.source      out_ch
);

  logic [3:0][7:0] pb_r;
  logic [2:0]      pre_r, pre_nxt;
  logic [2:0]      pass_r, pass_nxt;
  logic [1:0]      post_r, post_nxt;
  logic [1:0]      pos_r, pos_nxt;
  logic [1:0]      pidx_r, pidx_nxt;
  logic            last_r;
  logic            sval_r;

  logic [7:0] ob_r;
  logic       osub_r;
  logic       olast_r;
  logic       oval_r;
  logic       ovalid_r;

  logic       busy;
  logic       adv;
  logic       done;
  logic [7:0] cur_byte;
  logic       cur_sub;

  assign busy = (pre_r != 3'd0) || (pass_r != 3'd0) || (post_r != 2'd0);
  assign adv  = busy && (!ovalid_r || out_ch.ready);

  always_comb begin
    pre_nxt  = pre_r;
    pass_nxt = pass_r;
    post_nxt = post_r;
    pos_nxt  = pos_r;
    pidx_nxt = pidx_r;
    cur_byte = rep_byte(pos_r);
    cur_sub  = 1'b1;
    if (pre_r != 3'd0) begin
      if (pos_r == REP_LAST_POS) begin
        pos_nxt = 2'd0;
        pre_nxt = pre_r - 3'd1;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end else if (pass_r != 3'd0) begin
      cur_byte = pb_r[pidx_r];
      cur_sub  = 1'b0;
      pidx_nxt = pidx_r + 2'd1;
      pass_nxt = pass_r - 3'd1;
    end else begin
      if (pos_r == REP_LAST_POS) begin
        pos_nxt  = 2'd0;
        post_nxt = post_r - 2'd1;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  assign done  = (pre_nxt == 3'd0) && (pass_nxt == 3'd0) && (post_nxt == 2'd0);
  assign q_pop = !q_empty && (!busy || (adv && done));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r  <= 3'd0;
      pass_r <= 3'd0;
      post_r <= 2'd0;
      pos_r  <= 2'd0;
      pidx_r <= 2'd0;
    end else if (q_pop) begin
      pre_r  <= q_cmd.n_pre;
      pass_r <= q_cmd.n_pass;
      post_r <= q_cmd.n_post;
      pos_r  <= 2'd0;
      pidx_r <= 2'd0;
    end else if (adv) begin
      pre_r  <= pre_nxt;
      pass_r <= pass_nxt;
      post_r <= post_nxt;
      pos_r  <= pos_nxt;
      pidx_r <= pidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pb_r   <= q_cmd.pb;
      last_r <= q_cmd.last;
      sval_r <= q_cmd.str_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (adv) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ob_r    <= cur_byte;
      osub_r  <= cur_sub;
      olast_r <= done && last_r;
      oval_r  <= done && last_r && sval_r;
    end
  end

  assign out_ch.valid            = ovalid_r;
  assign out_ch.out_byte         = ob_r;
  assign out_ch.out_substituted  = osub_r;
  assign out_ch.out_last         = olast_r;
  assign out_ch.string_was_valid = oval_r;

`ifndef SYNTHESIS
  a_sub_not_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && osub_r) |-> !oval_r)
    else $error("replaced byte flagged as valid string");
  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pass_r != 3'd0) |-> (({1'b0, pidx_r} + pass_r) <= 3'd4))
    else $error("pass index beyond entry");
`endif

endmodule
`default_nettype wire

### src/utf8_replacement_sanitizer.sv
`default_nettype none
// channel  dir  fields                                                    handshake
// in_ch    in   in_byte[7:0], in_last                                     valid/ready
// out_ch   out  out_byte[7:0], out_substituted, out_last, string_was_valid valid/ready
//
// one input byte per cycle is taken while the command queue has room
// the back end sends one output byte per cycle while out_ch is ready and work is queued;
// a replacement is three output bytes, so one input byte can give up to twelve output bytes
// the four-entry command queue lets input keep flowing while out_ch stalls
// rst_n is synchronous; after reset no group is held and the string is clean
module utf8_replacement_sanitizer
  import u8san_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  u8san_in_if.sink     in_ch,
  u8san_out_if.source  out_ch
);

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  u8san_cmd_t q_wcmd;
  u8san_cmd_t q_rcmd;

  u8san_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_wcmd)
  );

  u8san_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_wcmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_rcmd),
    .empty    (q_empty)
  );

  u8san_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (q_rcmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

### tb/sv/utf8_replacement_sanitizer_tb.sv
`default_nettype none
module utf8_replacement_sanitizer_tb
  import u8san_pkg::*;
();

  localparam int LIMIT_TU    = 1_600_000;
  localparam int SETTLE_CYC  = 30;
  localparam int IDLE_PCT    = 24;
  localparam int STALL_CYC   = 120;

  typedef struct packed {
    logic [7:0] data;
    logic       sub;
    logic       last;
    logic       clean;
  } san_beat_t;

  logic clk;
  logic rst_n;

  u8san_in_if  in_ch();
  u8san_out_if out_ch();

  utf8_replacement_sanitizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // expected output bytes, oldest first
  san_beat_t  exp_q [$];
  int         fail_cnt;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         hold_cycles;

  // predictor state for the group being collected
  logic [7:0] grp_bytes [3];
  int         grp_cnt;
  int         grp_len;
  logic       str_dirty;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(LIMIT_TU);
    $display("FAILURE");
    $finish;
  end

  function automatic void push_beat(input logic [7:0] b, input logic sub);
    san_beat_t t;
    t.data  = b;
    t.sub   = sub;
    t.last  = 1'b0;
    t.clean = 1'b0;
    exp_q.push_back(t);
  endfunction

  function automatic void push_fffd();
    push_beat(REP_B0, 1'b1);
    push_beat(REP_B1, 1'b1);
    push_beat(REP_B2, 1'b1);
    str_dirty = 1'b1;
  endfunction

  function automatic void drop_group();
    for (int k = 0; k < grp_cnt; k++) push_fffd();
    grp_cnt = 0;
    grp_len = 1;
  endfunction

  // expected output for one accepted byte of the string
  function automatic void sanitize_byte(input logic [7:0] b, input logic lst);
    int        first;
    san_beat_t t;
    first = exp_q.size();
    if (grp_cnt > 0 && b[7:6] == 2'b10) begin
      if (grp_cnt + 1 >= grp_len) begin
        for (int k = 0; k < grp_cnt; k++) push_beat(grp_bytes[k], 1'b0);
        push_beat(b, 1'b0);
        grp_cnt = 0;
        grp_len = 1;
      end else begin
        grp_bytes[grp_cnt] = b;
        grp_cnt++;
      end
    end else begin
      if (grp_cnt > 0) drop_group();
      casez (b)
        8'b0???????: push_beat(b, 1'b0);
        8'b110?????: begin grp_bytes[0] = b; grp_cnt = 1; grp_len = 2; end
        8'b1110????: begin grp_bytes[0] = b; grp_cnt = 1; grp_len = 3; end
        8'b11110???: begin grp_bytes[0] = b; grp_cnt = 1; grp_len = 4; end
        default:     push_fffd();
      endcase
    end
    if (lst) begin
      if (grp_cnt > 0) drop_group();
      if (exp_q.size() > first) begin
        t = exp_q.pop_back();
        t.last  = 1'b1;
        t.clean = !str_dirty;
        exp_q.push_back(t);
      end
      grp_cnt   = 0;
      grp_len   = 1;
      str_dirty = 1'b0;
    end
  endfunction

  // receiver: random idling plus a counted hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    san_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (exp_q.size() == 0) begin
        $error("out_byte: no transaction expected, got %h", out_ch.out_byte);
        fail_cnt++;
      end else begin
        want = exp_q.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_ch.out_byte);
          fail_cnt++;
        end
        if (out_ch.out_substituted !== want.sub) begin
          $error("out_substituted: expected %b, got %b", want.sub, out_ch.out_substituted);
          fail_cnt++;
        end
        if (out_ch.out_last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_ch.out_last);
          fail_cnt++;
        end
        if (out_ch.string_was_valid !== want.clean) begin
          $error("string_was_valid: expected %b, got %b", want.clean,
                 out_ch.string_was_valid);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= lst;
    do @(posedge clk); while (!in_ch.ready);
    sanitize_byte(b, lst);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_ascii();
    send_byte(8'h41, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_valid_groups();
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_bad_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF8, 1'b1);
  endtask

  // breaking byte is rescanned as a fresh lead
  task automatic test_broken_groups();
    send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b1);
  endtask

  // group cut off by the end of the string, incl. the twelve-byte worst case
  task automatic test_cut_short();
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hC3, 1'b1);
  endtask

  // strings of mostly well-formed groups with some noise and broken groups
  task automatic test_random_text(input int n_items);
    logic [7:0] txt [$];
    logic [7:0] lead;
    int         sent;
    int         n_grp;
    int         kind;
    int         glen;
    int         ncont;
    int         bad_pos;
    sent = 0;
    while (sent < n_items) begin
      txt.delete();
      n_grp = $urandom_range(1, 8);
      repeat (n_grp) begin
        kind = $urandom_range(0, 99);
        glen = $urandom_range(1, 4);
        case (glen)
          1:       lead = 8'($urandom_range(1, 127));
          2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
          3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
          default: lead = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        if (kind >= 80 && kind < 88) begin
          txt.push_back(8'($urandom_range(1, 255)));
        end else begin
          ncont   = glen - 1;
          bad_pos = -1;
          if (kind >= 88 && kind < 94 && glen > 1) ncont = $urandom_range(0, glen - 2);
          if (kind >= 94 && glen > 1) bad_pos = $urandom_range(0, glen - 2);
          txt.push_back(lead);
          for (int k = 0; k < ncont; k++) begin
            if (k == bad_pos) txt.push_back(8'($urandom_range(1, 255)));
            else txt.push_back(8'h80 | 8'($urandom_range(0, 63)));
          end
        end
      end
      foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
      sent += txt.size();
    end
  endtask

  // receiver holds off while replacement-heavy bytes keep coming
  task automatic test_stall_fill();
    tx_idle_pct = 0;
    hold_cycles = STALL_CYC;
    for (int i = 0; i < 30; i++) begin
      send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 127))
                                            : 8'($urandom_range(128, 255)), i == 29);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    fail_cnt      = 0;
    hold_cycles   = 0;
    tx_idle_pct   = IDLE_PCT;
    rx_idle_pct   = IDLE_PCT;
    grp_cnt       = 0;
    grp_len       = 1;
    str_dirty     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_ascii();
    test_valid_groups();
    test_bad_leads();
    test_broken_groups();
    test_cut_short();
    wait_drained();

    test_random_text(80);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_text(40);
    rx_idle_pct = IDLE_PCT;
    test_stall_fill();
    wait_drained();

    tx_idle_pct = IDLE_PCT;
    test_random_text(30);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
